FILE: rtl/shpd_pkg.sv
package shpd_pkg;

    // Widest total pixel count the header can carry.
    localparam int LENGTH_BITS_DEF = 32;

    // Signature pixels, then count pixels; letters start after them.
    localparam int SIG_PIXELS    = 3;
    localparam int HEADER_PIXELS = 7;

    // Depth of the queue between the decode front and the output stage.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SIG_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SIG_SECOND = 2'd1;
    localparam logic [1:0] CFG_SIG_THIRD  = 2'd2;

    localparam logic [7:0] SIG_FIRST_RST  = 8'd78;
    localparam logic [7:0] SIG_SECOND_RST = 8'd105;
    localparam logic [7:0] SIG_THIRD_RST  = 8'd99;

    typedef enum logic [1:0] {
        ST_LETTER   = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] letter;
        t_status    status;
        logic       last;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    // Gathers the low three bits of each byte into a 12-bit Hamming code,
    // corrects a single error and returns the data byte.
    function automatic logic [7:0] hamming_extract(input logic [31:0] px);
        logic [11:0] c;
        logic [3:0]  syn;
        c = {px[26:24], px[18:16], px[10:8], px[2:0]};
        syn[0] = c[11] ^ c[9] ^ c[7] ^ c[5] ^ c[3] ^ c[1];
        syn[1] = c[10] ^ c[9] ^ c[6] ^ c[5] ^ c[2] ^ c[1];
        syn[2] = c[8] ^ c[7] ^ c[6] ^ c[5] ^ c[0];
        syn[3] = c[4] ^ c[3] ^ c[2] ^ c[1] ^ c[0];
        // Position p lives at code bit 12-p; syndromes above 12 flip nothing.
        if (syn >= 4'd1 && syn <= 4'd12) begin
            c = c ^ (12'd1 << (4'd12 - syn));
        end
        return {c[9], c[7:5], c[3:0]};
    endfunction

endpackage

FILE: rtl/shpd_front.sv
module shpd_front #(
    parameter int LENGTH_BITS = shpd_pkg::LENGTH_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_valid,
    input  logic [31:0]         i_pixel,
    input  logic                i_first,
    input  logic                i_space,
    output logic                o_ready,
    output logic                o_push,
    output shpd_pkg::t_result   o_result
);
    import shpd_pkg::*;

    localparam logic [LENGTH_BITS-1:0] SIG_END = LENGTH_BITS'(SIG_PIXELS);
    localparam logic [LENGTH_BITS-1:0] HDR_END = LENGTH_BITS'(HEADER_PIXELS);
    localparam logic [LENGTH_BITS-1:0] HDR_LAST = LENGTH_BITS'(HEADER_PIXELS - 1);

    logic [7:0]             r_sig_first;
    logic [7:0]             r_sig_second;
    logic [7:0]             r_sig_third;
    logic [LENGTH_BITS-1:0] r_idx;
    logic [LENGTH_BITS-1:0] r_total;
    logic                   r_fin;

    logic [LENGTH_BITS-1:0] n_idx;
    logic [LENGTH_BITS-1:0] n_total;
    logic                   n_fin;

    logic                   w_accept;
    logic [LENGTH_BITS-1:0] w_idx;
    logic [LENGTH_BITS-1:0] w_idx_next;
    logic [LENGTH_BITS-1:0] w_total;
    logic [LENGTH_BITS-1:0] w_total_shift;
    logic                   w_fin;
    logic [7:0]             w_byte;
    logic [7:0]             w_want;

    assign o_ready  = i_space;
    assign w_accept = i_valid && i_space;

    always_comb begin
        // A first-pixel flag restarts the image with this pixel as pixel zero.
        w_idx         = i_first ? '0 : r_idx;
        w_total       = i_first ? '0 : r_total;
        w_fin         = i_first ? 1'b0 : r_fin;
        w_idx_next    = w_idx + 1'b1;
        w_byte        = hamming_extract(i_pixel);
        w_total_shift = LENGTH_BITS'({w_total, w_byte});

        case (w_idx[1:0])
            2'd0:    w_want = r_sig_first;
            2'd1:    w_want = r_sig_second;
            default: w_want = r_sig_third;
        endcase

        n_idx           = r_idx;
        n_total         = r_total;
        n_fin           = r_fin;
        o_push          = 1'b0;
        o_result.letter = '0;
        o_result.status = ST_LETTER;
        o_result.last   = 1'b0;

        if (w_accept) begin
            n_idx   = w_idx;
            n_total = w_total;
            n_fin   = w_fin;
            if (!w_fin) begin
                n_idx = w_idx_next;
                if (w_idx < SIG_END) begin
                    if (w_byte != w_want) begin
                        n_fin           = 1'b1;
                        o_push          = 1'b1;
                        o_result.status = ST_MISMATCH;
                        o_result.last   = 1'b1;
                    end
                end else if (w_idx < HDR_END) begin
                    n_total = w_total_shift;
                    if (w_idx == HDR_LAST && w_total_shift <= HDR_END) begin
                        n_fin           = 1'b1;
                        o_push          = 1'b1;
                        o_result.status = ST_EMPTY;
                        o_result.last   = 1'b1;
                    end
                end else if (w_idx < w_total) begin
                    o_push          = 1'b1;
                    o_result.letter = w_byte;
                    o_result.last   = (w_idx_next == w_total);
                    n_fin           = (w_idx_next == w_total);
                end else begin
                    n_fin = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_first  <= SIG_FIRST_RST;
            r_sig_second <= SIG_SECOND_RST;
            r_sig_third  <= SIG_THIRD_RST;
            r_idx        <= '0;
            r_total      <= '0;
            r_fin        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SIG_FIRST:  r_sig_first  <= i_cfg_wdata;
                    CFG_SIG_SECOND: r_sig_second <= i_cfg_wdata;
                    CFG_SIG_THIRD:  r_sig_third  <= i_cfg_wdata;
                    default:        ;
                endcase
            end
            r_idx   <= n_idx;
            r_total <= n_total;
            r_fin   <= n_fin;
        end
    end

`ifndef SYNTH
    // The final word of an image always closes it.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_result.last |=> r_fin)
        else $error("final word did not close the image");

    // Status words are always the last word of their image.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_result.status != ST_LETTER |-> o_result.last)
        else $error("status word without last");

    // A closed image ignores pixels until the next first pixel.
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin && !(w_accept && i_first) |=> $stable(r_idx) && !$past(o_push))
        else $error("pixel index moved while the image was closed");
`endif

endmodule

FILE: rtl/shpd_fifo.sv
module shpd_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  shpd_pkg::t_result     i_data,
    input  logic                  i_pop,
    output shpd_pkg::t_result     o_data,
    output shpd_pkg::t_queue_stat o_stat
);
    import shpd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_result          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic             w_push;
    logic             w_pop;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign o_data       = r_mem[r_rd_ptr];
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("word pushed into a full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count out of range");
`endif

endmodule

FILE: rtl/shpd_back.sv
module shpd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  shpd_pkg::t_queue_stat i_stat,
    input  shpd_pkg::t_result     i_data,
    output logic                  o_pop,
    input  logic                  i_tready,
    output logic                  o_tvalid,
    output logic [7:0]            o_tdata,
    output logic [1:0]            o_tuser,
    output logic                  o_tlast
);
    import shpd_pkg::*;

    logic    r_valid;
    t_result r_word;

    // The output register reloads from a non-empty queue whenever it is empty or being taken.
    assign o_pop    = !i_stat.empty && (!r_valid || i_tready);
    assign o_tvalid = r_valid;
    assign o_tdata  = r_word.letter;
    assign o_tuser  = r_word.status;
    assign o_tlast  = r_word.last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

FILE: rtl/stego_hamming_pixel_decoder.sv
// Channel   Direction  Payload
// s_axis    in         tdata[31:0] pixel_word; tuser[0] first_pixel
// m_axis    out        tdata[7:0] letter; tuser[1:0] status; tlast last
// cfg       in         i_cfg_index selects a signature byte, i_cfg_wdata[7:0]
//
// One pixel word is taken every cycle while the queue has room; the decode front
// is combinational and writes into the queue, which the output register reads.
// A two-word queue sits between them, so input stalls only once it fills.
// Reset is synchronous and active low; it restores the signature bytes.
// Pixels that yield no result (matching signature pixels, count pixels that do not end the image) leave nothing queued.
module stego_hamming_pixel_decoder #(
    parameter int LENGTH_BITS = shpd_pkg::LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] pixel_word
    input  logic [0:0]  s_axis_tuser,   // [0] first_pixel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] letter
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);
    import shpd_pkg::*;

    logic        w_push;
    logic        w_pop;
    t_result     w_front_word;
    t_result     w_head_word;
    t_queue_stat w_stat;

    shpd_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .i_pixel     (s_axis_tdata),
        .i_first     (s_axis_tuser[0]),
        .i_space     (!w_stat.full),
        .o_ready     (s_axis_tready),
        .o_push      (w_push),
        .o_result    (w_front_word)
    );

    shpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_word),
        .i_pop   (w_pop),
        .o_data  (w_head_word),
        .o_stat  (w_stat)
    );

    shpd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stat   (w_stat),
        .i_data   (w_head_word),
        .o_pop    (w_pop),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

FILE: test/tb_stego_hamming_pixel_decoder.sv
`timescale 1ns / 1ps

module tb_stego_hamming_pixel_decoder;
    import shpd_pkg::*;

    localparam int LEN_BITS = LENGTH_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef enum {
        PX_CLEAN,
        PX_ONE_FLIP,
        PX_TWO_FLIP,
        PX_WILD
    } t_px_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [7:0]  i_cfg_wdata = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 32'd0;   // [31:0] pixel_word
    logic [0:0]  s_axis_tuser = 1'b0;    // [0] first_pixel
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [7:0] letter
    logic [1:0]  m_axis_tuser;           // [1:0] status
    logic        m_axis_tlast;

    stego_hamming_pixel_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Shadow of the signature registers and the image tracking state.
    logic [7:0]  sig_byte [3];
    logic [31:0] pix_idx;
    logic [31:0] pix_total;
    logic        img_done;
    t_result     words_due [$];

    int fail_count = 0;
    int pixels_sent = 0;
    int images_sent = 0;
    int burst_left = 0;
    int cycle_count = 0;
    int seen_letters = 0;
    int seen_mismatch = 0;
    int seen_empty = 0;

    // XOR of the positions of all set code bits; position p is code bit 12-p.
    function automatic logic [3:0] syndrome_of(input logic [11:0] c);
        logic [3:0] s;
        s = 4'd0;
        for (int p = 1; p <= 12; p++) begin
            if (c[12 - p]) begin
                s = s ^ 4'(p);
            end
        end
        return s;
    endfunction

    function automatic logic [7:0] recover_byte(input logic [31:0] px);
        logic [11:0] c;
        logic [3:0]  s;
        for (int k = 0; k < 4; k++) begin
            c[3 * k +: 3] = px[8 * k +: 3];
        end
        s = syndrome_of(c);
        if (s >= 4'd1 && s <= 4'd12) begin
            c[12 - s] = ~c[12 - s];
        end
        return {c[9], c[7], c[6], c[5], c[3], c[2], c[1], c[0]};
    endfunction

    // Builds a clean codeword: the parity positions 1, 2, 4 and 8 cancel the
    // syndrome of the data bits.
    function automatic logic [11:0] code_of(input logic [7:0] b);
        logic [11:0] c;
        logic [3:0]  s;
        c = 12'd0;
        c[9] = b[7];
        c[7:5] = b[6:4];
        c[3:0] = b[3:0];
        s = syndrome_of(c);
        c[11] = s[0];
        c[10] = s[1];
        c[8] = s[2];
        c[4] = s[3];
        return c;
    endfunction

    function automatic logic [31:0] pixel_of(input logic [7:0] b, input t_px_kind kind);
        logic [11:0] c;
        logic [31:0] px;
        int a;
        int z;
        c = code_of(b);
        case (kind)
            PX_ONE_FLIP: begin
                a = $urandom_range(0, 11);
                c[a] = ~c[a];
            end
            PX_TWO_FLIP: begin
                a = $urandom_range(0, 11);
                z = (a + $urandom_range(1, 11)) % 12;
                c[a] = ~c[a];
                c[z] = ~c[z];
            end
            PX_WILD: begin
                // A syndrome above twelve points at no position at all.
                do begin
                    c = 12'($urandom);
                end while (syndrome_of(c) < 4'd13);
            end
            default: ;
        endcase
        px = $urandom;
        for (int k = 0; k < 4; k++) begin
            px[8 * k +: 3] = c[3 * k +: 3];
        end
        return px;
    endfunction

    function automatic t_px_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return PX_CLEAN;
        if (r < 92) return PX_ONE_FLIP;
        if (r < 96) return PX_TWO_FLIP;
        return PX_WILD;
    endfunction

    task automatic clear_image_state();
        pix_idx = 32'd0;
        pix_total = 32'd0;
        img_done = 1'b0;
    endtask

    // Tracks one accepted pixel and queues the word it should produce.
    task automatic follow_image(input logic [31:0] px, input logic first);
        logic [7:0]  b;
        logic [31:0] i;
        logic        is_last;
        if (first) begin
            clear_image_state();
        end
        if (!img_done) begin
            b = recover_byte(px);
            i = pix_idx;
            pix_idx = i + 32'd1;
            if (i < SIG_PIXELS) begin
                if (b != sig_byte[i]) begin
                    img_done = 1'b1;
                    words_due.push_back('{letter: 8'd0, status: ST_MISMATCH, last: 1'b1});
                end
            end else if (i < HEADER_PIXELS) begin
                pix_total = pix_total | ({24'd0, b} << (8 * (6 - i)));
                if (i == HEADER_PIXELS - 1) begin
                    pix_total = pix_total & 32'((64'd1 << LEN_BITS) - 64'd1);
                    if (pix_total <= HEADER_PIXELS) begin
                        img_done = 1'b1;
                        words_due.push_back('{letter: 8'd0, status: ST_EMPTY, last: 1'b1});
                    end
                end
            end else if (i < pix_total) begin
                is_last = (i == pix_total - 32'd1);
                if (is_last) begin
                    img_done = 1'b1;
                end
                words_due.push_back('{letter: b, status: ST_LETTER, last: is_last});
            end else begin
                img_done = 1'b1;
            end
        end
    endtask

    task automatic push_pixel(input logic [31:0] px, input logic first);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        s_axis_tuser <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        follow_image(px, first);
        pixels_sent++;
    endtask

    // Sends signature, count and n_payload letter pixels of one image.
    task automatic send_image(input logic first0, input logic [31:0] count,
                              input int n_payload, input bit noisy);
        logic [7:0] b;
        t_px_kind   kind;
        for (int i = 0; i < HEADER_PIXELS + n_payload; i++) begin
            if (i < SIG_PIXELS) begin
                b = sig_byte[i];
            end else if (i < HEADER_PIXELS) begin
                b = count[8 * (6 - i) +: 8];
            end else begin
                b = 8'($urandom);
            end
            kind = noisy ? pick_kind() : PX_CLEAN;
            push_pixel(pixel_of(b, kind), (i == 0) ? first0 : 1'b0);
        end
        images_sent++;
    endtask

    // Lets every queued word arrive, then waits SETTLE_CYCLES more for pixels that
    // produce nothing but may still be in flight.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sig(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SIG_FIRST:  sig_byte[0] = val;
            CFG_SIG_SECOND: sig_byte[1] = val;
            CFG_SIG_THIRD:  sig_byte[2] = val;
            default: ;
        endcase
    endtask

    task automatic write_all_sigs(input logic [7:0] v0, input logic [7:0] v1,
                                  input logic [7:0] v2);
        write_sig(CFG_SIG_FIRST, v0);
        write_sig(CFG_SIG_SECOND, v1);
        write_sig(CFG_SIG_THIRD, v2);
    endtask

    task automatic test_directed_cases();
        // No first-pixel flag after reset: decoding still starts at pixel 0.
        send_image(1'b0, 32'd10, 0, 1'b0);
        push_pixel(pixel_of(8'h00, PX_CLEAN), 1'b0);
        push_pixel(pixel_of(8'hFF, PX_ONE_FLIP), 1'b0);
        push_pixel(pixel_of(8'h00, PX_WILD), 1'b0);
        // The image is finished, so this pixel must be ignored.
        push_pixel(32'hFFFF_FFFF, 1'b0);
        // Mismatch on each of the three signature pixels.
        push_pixel(32'h0000_0000, 1'b1);
        push_pixel(32'hFFFF_FFFF, 1'b0);
        push_pixel(pixel_of(sig_byte[0], PX_CLEAN), 1'b1);
        push_pixel(pixel_of(~sig_byte[1], PX_CLEAN), 1'b0);
        push_pixel(pixel_of(sig_byte[0], PX_ONE_FLIP), 1'b1);
        push_pixel(pixel_of(sig_byte[1], PX_ONE_FLIP), 1'b0);
        push_pixel(pixel_of(sig_byte[2] ^ 8'h01, PX_CLEAN), 1'b0);
        // A count of seven leaves no room for letters.
        send_image(1'b1, 32'd7, 0, 1'b0);
        wait_idle();
    endtask

    task automatic test_signature_config();
        write_all_sigs(8'h00, 8'hFF, 8'h80);
        send_image(1'b1, 32'd12, 5, 1'b1);
        push_pixel(pixel_of(8'h00, PX_CLEAN), 1'b1);
        push_pixel(pixel_of(8'hFE, PX_CLEAN), 1'b0);
        wait_idle();
        // The spare index must not disturb any signature.
        write_sig(CFG_UNUSED, 8'($urandom));
        send_image(1'b1, 32'd9, 2, 1'b0);
        wait_idle();
        write_all_sigs(8'hFF, 8'h00, 8'h7F);
        send_image(1'b1, 32'd10, 3, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_images();
        int target;
        int r;
        int n;
        int k;
        int count_in_phase;
        logic [31:0] cnt;
        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            case (phase)
                0: write_all_sigs(SIG_FIRST_RST, SIG_SECOND_RST, SIG_THIRD_RST);
                1: write_all_sigs(8'($urandom), 8'($urandom), 8'($urandom));
                2: write_all_sigs(8'h00, 8'h00, 8'h00);
                default: write_all_sigs(8'hFF, 8'hFF, 8'hFF);
            endcase
            target = pixels_sent + 260;
            count_in_phase = 0;
            while (pixels_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    cnt = 32'(8 + $urandom_range(0, 32));
                    n = int'(cnt) - HEADER_PIXELS;
                    if ($urandom_range(0, 4) == 0) begin
                        n = n + $urandom_range(1, 3);
                    end else if ($urandom_range(0, 7) == 0) begin
                        n = $urandom_range(0, n - 1);
                    end
                    send_image(1'b1, cnt, n, 1'b1);
                end else if (r < 75) begin
                    send_image(1'b1, 32'($urandom_range(0, 7)), $urandom_range(0, 2), 1'b1);
                end else if (r < 85) begin
                    k = $urandom_range(0, 2);
                    for (int i = 0; i < k; i++) begin
                        push_pixel(pixel_of(sig_byte[i], pick_kind()), i == 0);
                    end
                    push_pixel(pixel_of(sig_byte[k] ^ 8'($urandom_range(1, 255)), PX_CLEAN),
                               k == 0);
                    n = $urandom_range(0, 3);
                    repeat (n) push_pixel($urandom, 1'b0);
                    images_sent++;
                end else if (r < 92) begin
                    // Huge counts are cut short by the next image.
                    cnt = $urandom;
                    if (cnt < 8) begin
                        cnt = cnt + 32'd8;
                    end
                    send_image(1'b1, cnt, $urandom_range(0, 10), 1'b1);
                end else begin
                    n = $urandom_range(1, 6);
                    repeat (n) push_pixel($urandom, 1'($urandom_range(0, 1)));
                end
                count_in_phase++;
                if (count_in_phase % 15 == 0) begin
                    wait_idle();
                end
            end
        end
    endtask

    // Receiver: a ready pattern that changes its character every so often.
    int rdy_mode = 0;
    int rdy_left = 0;
    int rdy_phase = 0;
    always @(negedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = $urandom_range(20, 200);
        end
        rdy_left--;
        rdy_phase = (rdy_phase + 1) % 10;
        case (rdy_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 7) != 0);
            default: m_axis_tready <= (rdy_phase < 4);
        endcase
    end

    always @(posedge i_clk) begin : check_out
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (words_due.size() == 0) begin
                $error("unexpected word: letter %0h status %0d last %0b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fail_count++;
            end else begin
                want = words_due.pop_front();
                if (m_axis_tdata !== want.letter) begin
                    $error("letter: expected %0h, actual %0h", want.letter, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
                    fail_count++;
                end
                case (want.status)
                    ST_LETTER:   seen_letters++;
                    ST_MISMATCH: seen_mismatch++;
                    default:     seen_empty++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still due",
                     cycle_count, words_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        sig_byte[0] = SIG_FIRST_RST;
        sig_byte[1] = SIG_SECOND_RST;
        sig_byte[2] = SIG_THIRD_RST;
        clear_image_state();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_signature_config();
        test_random_images();
        wait_idle();

        $display("Sent %0d pixels in %0d images; checked %0d letters, %0d mismatches, %0d empty.",
                 pixels_sent, images_sent, seen_letters, seen_mismatch, seen_empty);
        $display("Signatures ran at reset, random, all-zero and all-one settings.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
